/* hw/rtl/bellman_ford_shortest_paths_macros.svh */
// Assertion macros for the shortest-path engine.
// Included by the modules that check their own logic; no other dependencies.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold on every clock edge outside reset
`define BFSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BFSP_ASSERT(label, clk, rst_n, prop, msg)
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/bfsp_pkg.sv */
// Shared types, codes and constants for the shortest-path engine.
// No dependencies; used by bfsp_edge_store and bellman_ford_shortest_paths.
package bfsp_pkg;

    // default sizes
    localparam int NUM_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int WEIGHT_WIDTH_DEF = 16;
    localparam int DIST_WIDTH_DEF   = 32;

    // fixed field widths on the streams
    localparam int VTX_W       = 8;
    localparam int IN_WEIGHT_W = 16;
    localparam int OUT_DIST_W  = 32;
    localparam int SWEEP_W     = 9;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NEG_CYCLE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP_BEGIN,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_SUM,
        S_RELAX,
        S_SWEEP_END,
        S_QUERY
    } t_state;

    // edge store control from the sequencer
    typedef struct packed {
        logic clear;
        logic append;
    } t_es_ctl;

    // index width for an array of n entries
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // width of a counter that holds 0..n
    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

/* hw/rtl/bfsp_edge_store.sv */
// Edge list memory with fill count and full flag for the shortest-path engine.
// Depends on bfsp_pkg and bellman_ford_shortest_paths_macros.svh.
`include "bellman_ford_shortest_paths_macros.svh"
module bfsp_edge_store #(
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_WIDTH = bfsp_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  bfsp_pkg::t_es_ctl                           i_ctl,
    input  logic [bfsp_pkg::VTX_W-1:0]                  i_src,
    input  logic [bfsp_pkg::VTX_W-1:0]                  i_dst,
    input  logic signed [WEIGHT_WIDTH-1:0]              i_weight,
    input  logic [bfsp_pkg::idx_w(MAX_EDGES)-1:0]       i_rd_addr,
    output logic [bfsp_pkg::VTX_W-1:0]                  o_src,
    output logic [bfsp_pkg::VTX_W-1:0]                  o_dst,
    output logic signed [WEIGHT_WIDTH-1:0]              o_weight,
    output logic [bfsp_pkg::cnt_w(MAX_EDGES)-1:0]       o_count,
    output logic                                        o_full
);

    localparam int AW = bfsp_pkg::idx_w(MAX_EDGES);
    localparam int CW = bfsp_pkg::cnt_w(MAX_EDGES);
    localparam int EW = 2 * bfsp_pkg::VTX_W + WEIGHT_WIDTH;

    logic [EW-1:0] mem [MAX_EDGES];
    logic [EW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          wr_en;

    assign o_full = (32'(r_count) == MAX_EDGES);
    assign wr_en  = i_ctl.append && !o_full;

    // fill count
    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (wr_en) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // one write port at the fill position, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= {i_weight, i_dst, i_src};
        end
        r_rd <= mem[i_rd_addr];
    end

    assign o_src    = r_rd[bfsp_pkg::VTX_W-1:0];
    assign o_dst    = r_rd[2*bfsp_pkg::VTX_W-1:bfsp_pkg::VTX_W];
    assign o_weight = r_rd[EW-1:2*bfsp_pkg::VTX_W];
    assign o_count  = r_count;

    `BFSP_ASSERT(a_count_bound, i_clk, i_rst_n, (32'(r_count) <= MAX_EDGES), "edge count beyond capacity")
    `BFSP_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_ctl.clear, (r_count == '0), "clear left edges")
    `BFSP_ASSERT_NEXT(a_full_drops, i_clk, i_rst_n, (i_ctl.append && o_full && !i_ctl.clear), $stable(r_count), "append grew a full store")

endmodule

/* hw/rtl/bellman_ford_shortest_paths.sv */
// Bellman-Ford shortest-path engine: top level with sequencer and distance memory.
// Depends on bfsp_pkg, bfsp_edge_store and bellman_ford_shortest_paths_macros.svh.
//
// Each input item is one command and gives exactly one result item. Clear and
// add-edge finish in the accept cycle; a query passes through S_QUERY for the
// registered read of the distance memory. A run sweeps the edge list for up to
// NUM_VERTICES sweeps; each sweep passes SWEEP_BEGIN and SWEEP_END, an edge whose
// source is unreached or whose endpoints are out of range passes EDGE_RD and
// EDGE_CHK only, and an edge that is evaluated passes EDGE_RD, EDGE_CHK, SUM and
// RELAX. These steps come from the single read port of the distance memory,
// which is read once for the source and once for the destination, behind the
// registered read of the edge memory and the registered saturating adder. The
// input is not ready while a command is in progress. Reached flags are
// flip-flops and clear all at once; edge and distance memories need no sweep.
`include "bellman_ford_shortest_paths_macros.svh"
module bellman_ford_shortest_paths #(
    parameter int NUM_VERTICES = bfsp_pkg::NUM_VERTICES_DEF,
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_WIDTH = bfsp_pkg::WEIGHT_WIDTH_DEF,
    parameter int DIST_WIDTH   = bfsp_pkg::DIST_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] edge_from, [15:8] edge_to, [31:16] edge_weight,
    // [39:32] start_vertex, [47:40] query_vertex
    input  logic [bfsp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [bfsp_pkg::KIND_W-1:0]     s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] distance, [32] reached, [34:33] status, [43:35] sweeps_used,
    // [47:44] zero
    output logic [bfsp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int VW   = bfsp_pkg::idx_w(NUM_VERTICES);
    localparam int AW   = bfsp_pkg::idx_w(MAX_EDGES);
    localparam int CW   = bfsp_pkg::cnt_w(MAX_EDGES);
    localparam int SW   = bfsp_pkg::cnt_w(NUM_VERTICES);
    localparam int DW   = DIST_WIDTH;
    localparam int SUMW = ((DIST_WIDTH > WEIGHT_WIDTH) ? DIST_WIDTH : WEIGHT_WIDTH) + 1;
    localparam int XW   = (DIST_WIDTH > bfsp_pkg::OUT_DIST_W) ? DIST_WIDTH
                                                             : bfsp_pkg::OUT_DIST_W;
    localparam int OW   = bfsp_pkg::OUT_DIST_W;
    localparam int PADW = bfsp_pkg::M_TDATA_W - OW - 1 - 2 - bfsp_pkg::SWEEP_W;

    // input fields
    bfsp_pkg::t_kind                     in_kind;
    logic [bfsp_pkg::VTX_W-1:0]          in_from;
    logic [bfsp_pkg::VTX_W-1:0]          in_to;
    logic signed [bfsp_pkg::IN_WEIGHT_W-1:0] in_weight;
    logic [bfsp_pkg::VTX_W-1:0]          in_start;
    logic [bfsp_pkg::VTX_W-1:0]          in_query;

    assign in_kind   = bfsp_pkg::t_kind'(s_axis_tuser);
    assign in_from   = s_axis_tdata[7:0];
    assign in_to     = s_axis_tdata[15:8];
    assign in_weight = s_axis_tdata[31:16];
    assign in_start  = s_axis_tdata[39:32];
    assign in_query  = s_axis_tdata[47:40];

    // sequencer state and datapath registers
    bfsp_pkg::t_state         r_state, n_state;
    bfsp_pkg::t_status        r_run_status, n_run_status;
    logic [bfsp_pkg::SWEEP_W-1:0] r_sweep_count, n_sweep_count;
    logic [AW-1:0]            r_edge_idx, n_edge_idx;
    logic [SW-1:0]            r_sweeps, n_sweeps;
    logic                     r_changed, n_changed;
    logic signed [DW-1:0]     r_cand, n_cand;
    logic                     r_q_hit, n_q_hit;
    logic                     r_m_tvalid, n_m_tvalid;
    logic [bfsp_pkg::M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [NUM_VERTICES-1:0]  r_reached, n_reached;

    // distance memory
    logic signed [DW-1:0]     dist_mem [NUM_VERTICES];
    logic signed [DW-1:0]     r_dist_rd;
    logic [VW-1:0]            dm_raddr;
    logic                     dm_we;
    logic [VW-1:0]            dm_waddr;
    logic signed [DW-1:0]     dm_wdata;

    // reached flag control
    logic                     rch_clear;
    logic                     rch_set;
    logic [VW-1:0]            rch_idx;

    // edge store
    bfsp_pkg::t_es_ctl        es_ctl;
    logic [bfsp_pkg::VTX_W-1:0] es_src;
    logic [bfsp_pkg::VTX_W-1:0] es_dst;
    logic signed [WEIGHT_WIDTH-1:0] es_weight;
    logic [CW-1:0]            es_count;
    logic                     es_full;

    // handshakes and decoded conditions
    logic s_fire;
    logic start_ok, query_ok, src_ok, dst_ok, edge_live, last_edge;
    logic sweep_done, better;
    logic [VW-1:0] start_idx, query_idx, src_idx, dst_idx;
    logic signed [SUMW-1:0] sum;
    logic signed [DW-1:0]   sum_sat;
    logic signed [XW-1:0]   dist_x;
    logic signed [OW-1:0]   dist_out;
    logic [bfsp_pkg::SWEEP_W-1:0] sweeps_sat;

    assign s_axis_tready = (r_state == bfsp_pkg::S_IDLE) && (!r_m_tvalid || m_axis_tready);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    assign start_idx = VW'(in_start);
    assign query_idx = VW'(in_query);
    assign src_idx   = VW'(es_src);
    assign dst_idx   = VW'(es_dst);
    assign start_ok  = (32'(in_start) < NUM_VERTICES);
    assign query_ok  = (32'(in_query) < NUM_VERTICES);
    assign src_ok    = (32'(es_src) < NUM_VERTICES);
    assign dst_ok    = (32'(es_dst) < NUM_VERTICES);
    assign edge_live = src_ok && dst_ok && r_reached[src_idx];
    assign last_edge = ((CW'(r_edge_idx) + CW'(1)) == es_count);
    assign sweep_done = !r_changed || (32'(r_sweeps) == NUM_VERTICES);

    // saturating adder: distance of source plus edge weight
    assign sum = SUMW'(r_dist_rd) + SUMW'(es_weight);
    always_comb begin
        if (sum[SUMW-1:DW-1] == {(SUMW-DW+1){sum[DW-1]}}) begin
            sum_sat = sum[DW-1:0];
        end else if (sum[SUMW-1]) begin
            sum_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // comparator for relaxation
    assign better = !r_reached[dst_idx] || (r_cand < r_dist_rd);

    // query result clamped to the output width
    assign dist_x = XW'(r_dist_rd);
    always_comb begin
        if (dist_x[XW-1:OW-1] == {(XW-OW+1){dist_x[OW-1]}}) begin
            dist_out = dist_x[OW-1:0];
        end else if (dist_x[XW-1]) begin
            dist_out = {1'b1, {(OW-1){1'b0}}};
        end else begin
            dist_out = {1'b0, {(OW-1){1'b1}}};
        end
    end

    assign sweeps_sat = (32'(r_sweeps) > 511) ? {bfsp_pkg::SWEEP_W{1'b1}}
                                               : bfsp_pkg::SWEEP_W'(r_sweeps);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfsp_pkg::S_IDLE: begin
                if (s_fire) begin
                    if (in_kind == bfsp_pkg::KIND_RUN) begin
                        n_state = bfsp_pkg::S_SWEEP_BEGIN;
                    end else if (in_kind == bfsp_pkg::KIND_QUERY) begin
                        n_state = bfsp_pkg::S_QUERY;
                    end
                end
            end
            bfsp_pkg::S_SWEEP_BEGIN: begin
                n_state = (es_count == '0) ? bfsp_pkg::S_SWEEP_END : bfsp_pkg::S_EDGE_RD;
            end
            bfsp_pkg::S_EDGE_RD: begin
                n_state = bfsp_pkg::S_EDGE_CHK;
            end
            bfsp_pkg::S_EDGE_CHK: begin
                if (edge_live) begin
                    n_state = bfsp_pkg::S_SUM;
                end else begin
                    n_state = last_edge ? bfsp_pkg::S_SWEEP_END : bfsp_pkg::S_EDGE_RD;
                end
            end
            bfsp_pkg::S_SUM: begin
                n_state = bfsp_pkg::S_RELAX;
            end
            bfsp_pkg::S_RELAX: begin
                n_state = last_edge ? bfsp_pkg::S_SWEEP_END : bfsp_pkg::S_EDGE_RD;
            end
            bfsp_pkg::S_SWEEP_END: begin
                n_state = sweep_done ? bfsp_pkg::S_IDLE : bfsp_pkg::S_SWEEP_BEGIN;
            end
            bfsp_pkg::S_QUERY: begin
                n_state = bfsp_pkg::S_IDLE;
            end
            default: begin
                n_state = bfsp_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and next register values
    always_comb begin
        n_run_status  = r_run_status;
        n_sweep_count = r_sweep_count;
        n_edge_idx    = r_edge_idx;
        n_sweeps      = r_sweeps;
        n_changed     = r_changed;
        n_cand        = r_cand;
        n_q_hit       = r_q_hit;
        n_m_tvalid    = r_m_tvalid && !m_axis_tready;
        n_m_tdata     = r_m_tdata;
        es_ctl        = '0;
        dm_raddr      = query_idx;
        dm_we         = 1'b0;
        dm_waddr      = dst_idx;
        dm_wdata      = r_cand;
        rch_clear     = 1'b0;
        rch_set       = 1'b0;
        rch_idx       = dst_idx;

        case (r_state)
            bfsp_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (in_kind)
                        bfsp_pkg::KIND_CLEAR: begin
                            es_ctl.clear  = 1'b1;
                            rch_clear     = 1'b1;
                            n_run_status  = bfsp_pkg::ST_OK;
                            n_sweep_count = '0;
                            n_m_tvalid    = 1'b1;
                            n_m_tdata     = '0;
                        end
                        bfsp_pkg::KIND_ADD: begin
                            es_ctl.append = 1'b1;
                            n_m_tvalid    = 1'b1;
                            n_m_tdata     = {{PADW{1'b0}}, r_sweep_count,
                                             es_full ? bfsp_pkg::ST_FULL : bfsp_pkg::ST_OK,
                                             1'b0, {OW{1'b0}}};
                        end
                        bfsp_pkg::KIND_RUN: begin
                            rch_clear    = 1'b1;
                            rch_set      = start_ok;
                            rch_idx      = start_idx;
                            dm_we        = start_ok;
                            dm_waddr     = start_idx;
                            dm_wdata     = '0;
                            n_run_status = bfsp_pkg::ST_OK;
                            n_sweeps     = '0;
                        end
                        bfsp_pkg::KIND_QUERY: begin
                            n_q_hit = query_ok && r_reached[query_idx];
                        end
                        default: begin
                            n_q_hit = 1'b0;
                        end
                    endcase
                end
            end
            bfsp_pkg::S_SWEEP_BEGIN: begin
                n_sweeps   = r_sweeps + SW'(1);
                n_changed  = 1'b0;
                n_edge_idx = '0;
            end
            bfsp_pkg::S_EDGE_CHK: begin
                // read source distance; skip dead edges
                dm_raddr = src_idx;
                if (!edge_live && !last_edge) begin
                    n_edge_idx = r_edge_idx + AW'(1);
                end
            end
            bfsp_pkg::S_SUM: begin
                // register candidate, read destination distance
                n_cand   = sum_sat;
                dm_raddr = dst_idx;
            end
            bfsp_pkg::S_RELAX: begin
                if (better) begin
                    dm_we     = 1'b1;
                    rch_set   = 1'b1;
                    n_changed = 1'b1;
                end
                if (!last_edge) begin
                    n_edge_idx = r_edge_idx + AW'(1);
                end
            end
            bfsp_pkg::S_SWEEP_END: begin
                if (sweep_done) begin
                    n_run_status  = r_changed ? bfsp_pkg::ST_NEG_CYCLE : bfsp_pkg::ST_OK;
                    n_sweep_count = sweeps_sat;
                    n_m_tvalid    = 1'b1;
                    n_m_tdata     = {{PADW{1'b0}}, sweeps_sat,
                                     r_changed ? bfsp_pkg::ST_NEG_CYCLE : bfsp_pkg::ST_OK,
                                     1'b0, {OW{1'b0}}};
                end
            end
            bfsp_pkg::S_QUERY: begin
                n_m_tvalid = 1'b1;
                n_m_tdata  = {{PADW{1'b0}}, r_sweep_count, r_run_status,
                              r_q_hit, r_q_hit ? dist_out : {OW{1'b0}}};
            end
            default: begin
                n_m_tvalid = r_m_tvalid && !m_axis_tready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bfsp_pkg::S_IDLE;
            r_run_status  <= bfsp_pkg::ST_OK;
            r_sweep_count <= '0;
            r_edge_idx    <= '0;
            r_sweeps      <= '0;
            r_changed     <= 1'b0;
            r_q_hit       <= 1'b0;
            r_m_tvalid    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_run_status  <= n_run_status;
            r_sweep_count <= n_sweep_count;
            r_edge_idx    <= n_edge_idx;
            r_sweeps      <= n_sweeps;
            r_changed     <= n_changed;
            r_q_hit       <= n_q_hit;
            r_m_tvalid    <= n_m_tvalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cand    <= n_cand;
        r_m_tdata <= n_m_tdata;
    end

    // reached flags: clear all at once, set one per cycle
    always_comb begin
        n_reached = rch_clear ? '0 : r_reached;
        if (rch_set) begin
            n_reached[rch_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= '0;
        end else begin
            r_reached <= n_reached;
        end
    end

    // distance memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dist_mem[dm_waddr] <= dm_wdata;
        end
        r_dist_rd <= dist_mem[dm_raddr];
    end

    bfsp_edge_store #(
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_edge_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (es_ctl),
        .i_src     (in_from),
        .i_dst     (in_to),
        .i_weight  (WEIGHT_WIDTH'(in_weight)),
        .i_rd_addr (r_edge_idx),
        .o_src     (es_src),
        .o_dst     (es_dst),
        .o_weight  (es_weight),
        .o_count   (es_count),
        .o_full    (es_full)
    );

    `BFSP_ASSERT(a_sweep_bound, i_clk, i_rst_n,
        (32'(r_sweeps) <= NUM_VERTICES), "sweep count past vertex count")
    `BFSP_ASSERT(a_edge_idx_live, i_clk, i_rst_n,
        ((r_state == bfsp_pkg::S_EDGE_CHK || r_state == bfsp_pkg::S_SUM ||
          r_state == bfsp_pkg::S_RELAX) |-> (CW'(r_edge_idx) < es_count)),
        "edge index beyond stored edges")
    `BFSP_ASSERT_NEXT(a_run_result, i_clk, i_rst_n,
        (r_state == bfsp_pkg::S_SWEEP_END && n_state == bfsp_pkg::S_IDLE), r_m_tvalid,
        "finished run gave no result")

endmodule
